// ===== sv/lifo_stack_with_dup_swap_core_assert.svh =====
// assertion macros for the lifo stack core
`ifndef LIFO_STACK_WITH_DUP_SWAP_CORE_ASSERT_SVH
`define LIFO_STACK_WITH_DUP_SWAP_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define LSDS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lifo stack check failed");

// next-cycle implication, sampled on clk, off while in reset
`define LSDS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lifo stack check failed");

`endif

// ===== sv/lsds_pkg.sv =====
// shared types and constants for the lifo stack core
package lsds_pkg;

	localparam int unsigned WORD_W  = 64;
	localparam int unsigned KIND_W  = 3;
	localparam int unsigned DEPTH_W = 8;
	localparam int unsigned STAT_W  = 2;

	typedef logic [WORD_W-1:0]  word_t;
	typedef logic [DEPTH_W-1:0] depth_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_PUSH  = 3'd0,
		KIND_POP   = 3'd1,
		KIND_TOP   = 3'd2,
		KIND_DUP   = 3'd3,
		KIND_SWAP  = 3'd4,
		KIND_CLEAR = 3'd5
	} kind_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

endpackage

// ===== sv/lsds_in_if.sv =====
// command channel: operation kind and word to push
interface lsds_in_if;
	logic                   valid;
	logic                   ready;
	logic [2:0]             kind;
	lsds_pkg::word_t        push_word;

	modport source (output valid, output kind, output push_word, input ready);
	modport sink   (input valid, input kind, input push_word, output ready);
endinterface

// ===== sv/lsds_out_if.sv =====
// response channel: word read, depth after the operation and status
interface lsds_out_if;
	logic                   valid;
	logic                   ready;
	lsds_pkg::word_t        read_word;
	lsds_pkg::depth_t       depth;
	logic [1:0]             status;

	modport source (output valid, output read_word, output depth, output status, input ready);
	modport sink   (input valid, input read_word, input depth, input status, output ready);
endinterface

// ===== sv/lifo_stack_with_dup_swap_core.sv =====
// bounded lifo stack of 64-bit words with push, pop, top, duplicate, swap and clear
//
// usage
//   cmd : one word per operation, kind (push, pop, top, duplicate, swap, clear) and
//         push_word, taken when valid and ready are both high
//   rsp : exactly one word per command: read_word (pop/top result, else zero),
//         depth after the operation (low 8 bits of the count) and status
//         (ok, full when a push or duplicate was dropped, empty when a zero was read)
//   a command taken into the input register has its response loaded into the
//   response register and shown valid once that register is free
//   throughput is one command per cycle while rsp does not stall; the top two entries
//   sit in flip-flops and the memory below them has one write and one registered read
//   per cycle, the read always prefetching the third entry for the next operation
//   when rsp stalls, the response register holds its word and the input stage
//   holds one command, then cmd.ready drops until rsp drains
//   reset empties the stack at once (pointer to zero, both stages invalid); the
//   memory is not cleared and needs no clearing pass, entries above the pointer
//   are never read
module lifo_stack_with_dup_swap_core #(
	parameter int unsigned STACK_DEPTH = 128
) (
	input  logic              clk,
	input  logic              arst_n,
	lsds_in_if.sink           cmd,
	lsds_out_if.source        rsp
);

	`include "lifo_stack_with_dup_swap_core_assert.svh"

	localparam int unsigned PTR_W  = $clog2(STACK_DEPTH + 1);
	localparam int unsigned ADDR_W = $clog2(STACK_DEPTH);
	localparam logic [PTR_W-1:0] SP_MAX = PTR_W'(STACK_DEPTH);
	localparam logic [PTR_W-1:0] SP_ONE = PTR_W'(1);
	localparam logic [PTR_W-1:0] SP_TWO = PTR_W'(2);
	localparam logic [PTR_W-1:0] SP_THR = PTR_W'(3);

	// input stage
	logic                 valid_s1;
	lsds_pkg::kind_t      kind_s1;
	lsds_pkg::word_t      word_s1;

	// stack pointer, cached top two entries and prefetched third entry
	logic [PTR_W-1:0]     sp_q;
	lsds_pkg::word_t      top_q;
	lsds_pkg::word_t      next_q;
	lsds_pkg::word_t      third_q;

	// response register
	logic                 res_valid_q;
	lsds_pkg::word_t      res_word_q;
	lsds_pkg::depth_t     res_depth_q;
	lsds_pkg::status_t    res_status_q;

	// entries below the cached pair
	lsds_pkg::word_t      mem [STACK_DEPTH];

	logic                 res_free;
	logic                 adv;
	logic [PTR_W-1:0]     sp_d;
	logic [PTR_W-1:0]     sp_m2;
	logic [PTR_W-1:0]     sp_d_m3;
	logic [ADDR_W-1:0]    waddr;
	logic [ADDR_W-1:0]    raddr;
	logic                 spill;
	logic                 mem_we;
	logic                 not_full;
	logic                 has_one;
	logic                 has_two;
	lsds_pkg::word_t      top_d;
	lsds_pkg::word_t      next_d;
	lsds_pkg::word_t      rd_d;
	lsds_pkg::status_t    status_d;
	logic [PTR_W-1:0]     sp_op;

	// handshake: the response register frees when empty or being taken
	assign res_free  = !res_valid_q || rsp.ready;
	assign adv       = valid_s1 && res_free;
	assign cmd.ready = !valid_s1 || res_free;

	assign not_full = sp_q < SP_MAX;
	assign has_one  = sp_q != '0;
	assign has_two  = sp_q >= SP_TWO;

	// one operation on the cached top pair and the pointer
	always_comb begin
		top_d    = top_q;
		next_d   = next_q;
		sp_op    = sp_q;
		rd_d     = '0;
		status_d = lsds_pkg::ST_OK;
		spill    = 1'b0;
		case (kind_s1)
			lsds_pkg::KIND_PUSH: begin
				if (not_full) begin
					spill  = has_two;
					next_d = top_q;
					top_d  = word_s1;
					sp_op  = sp_q + SP_ONE;
				end else begin
					status_d = lsds_pkg::ST_FULL;
				end
			end
			lsds_pkg::KIND_POP: begin
				if (has_one) begin
					rd_d   = top_q;
					top_d  = next_q;
					next_d = third_q;
					sp_op  = sp_q - SP_ONE;
				end else begin
					status_d = lsds_pkg::ST_EMPTY;
				end
			end
			lsds_pkg::KIND_TOP: begin
				if (has_one) begin
					rd_d = top_q;
				end else begin
					status_d = lsds_pkg::ST_EMPTY;
				end
			end
			lsds_pkg::KIND_DUP: begin
				if (!has_one) begin
					// empty read gives zero, and the zero is still pushed
					top_d    = '0;
					sp_op    = SP_ONE;
					status_d = lsds_pkg::ST_EMPTY;
				end else if (not_full) begin
					spill  = has_two;
					next_d = top_q;
					sp_op  = sp_q + SP_ONE;
				end else begin
					status_d = lsds_pkg::ST_FULL;
				end
			end
			lsds_pkg::KIND_SWAP: begin
				if (has_two) begin
					top_d  = next_q;
					next_d = top_q;
				end else begin
					// missing entries read as zero and are pushed back
					top_d    = '0;
					next_d   = has_one ? top_q : '0;
					sp_op    = SP_TWO;
					status_d = lsds_pkg::ST_EMPTY;
				end
			end
			lsds_pkg::KIND_CLEAR: begin
				sp_op = '0;
			end
			default: begin
			end
		endcase
	end

	assign sp_d    = adv ? sp_op : sp_q;
	assign sp_m2   = sp_q - SP_TWO;
	assign sp_d_m3 = sp_d - SP_THR;
	assign waddr   = sp_m2[ADDR_W-1:0];
	assign raddr   = sp_d_m3[ADDR_W-1:0];
	assign mem_we  = adv && spill;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			kind_s1 <= lsds_pkg::kind_t'(cmd.kind);
			word_s1 <= cmd.push_word;
		end
	end

	// pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
		end else begin
			sp_q <= sp_d;
		end
	end

	// cached pair, no reset: garbage above the pointer is never read
	always_ff @(posedge clk) begin
		if (adv) begin
			top_q  <= top_d;
			next_q <= next_d;
		end
	end

	// spill store and prefetch of the entry under the cached pair,
	// bypassed when that entry is being spilled in the same cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= next_q;
		end
		if (mem_we && waddr == raddr) begin
			third_q <= next_q;
		end else begin
			third_q <= mem[raddr];
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_free) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_word_q   <= rd_d;
			res_depth_q  <= lsds_pkg::DEPTH_W'(sp_op);
			res_status_q <= status_d;
		end
	end

	assign rsp.valid     = res_valid_q;
	assign rsp.read_word = res_word_q;
	assign rsp.depth     = res_depth_q;
	assign rsp.status    = res_status_q;

	// checks
	`LSDS_ASSERT_NOW(a_sp_bound, 1'b1, sp_q <= SP_MAX)
	`LSDS_ASSERT_NEXT(a_full_at_top, adv && status_d == lsds_pkg::ST_FULL, sp_q == SP_MAX)
	`LSDS_ASSERT_NEXT(a_sp_holds, !adv, $stable(sp_q))
	`LSDS_ASSERT_NOW(a_empty_zero, res_valid_q && res_status_q == lsds_pkg::ST_EMPTY,
		res_word_q == '0)

endmodule
